>>> sv/lpd_pkg.sv
// lpd_pkg: shared constants, types and register indexes of the local peak detector
// depends on nothing; lpd_rsp_reg, the core and the bench use it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

   localparam int MAX_COLS   = 32;
   localparam int MAX_ROWS   = 1024;
   localparam int VALUE_BITS = 16;

   localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LINE_BITS = 2 * VALUE_BITS;

   localparam int CFG_ROWS_BITS  = 11;
   localparam int CFG_COLS_BITS  = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_ROWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_COLS = 2'd1;

   localparam logic [CFG_ROWS_BITS-1:0] ROWS_RESET = 11'd16;
   localparam logic [CFG_COLS_BITS-1:0] COLS_RESET = 6'd16;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
      logic                is_peak;
      logic                frame_end;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RD_C  = 5'b00010,
      S_RD_N  = 5'b00100,
      S_EVAL  = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> sv/lpd_ram.sv
// lpd_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module lpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/lpd_rsp_reg.sv
// lpd_rsp_reg: output register of the result channel, holds one item under stall
// depends on lpd_pkg for the result item struct
`timescale 1ns / 1ps
`default_nettype none

module lpd_rsp_reg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire lpd_pkg::rsp_type                item,
   output logic                                 free,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [lpd_pkg::ROW_BITS-1:0]         rsp_peak_row,
   output logic [lpd_pkg::COL_BITS-1:0]         rsp_peak_col,
   output logic                                 rsp_is_peak,
   output logic                                 rsp_frame_end
);

   logic             valid_ff;
   logic             valid_in;
   lpd_pkg::rsp_type item_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_peak_row  = item_ff.row;
   assign rsp_peak_col  = item_ff.col;
   assign rsp_is_peak   = item_ff.is_peak;
   assign rsp_frame_end = item_ff.frame_end;

endmodule

`default_nettype wire

>>> sv/raster_local_peak_detect_core.sv
// raster_local_peak_detect_core: 4-neighbour local maximum detection on a raster stream
// depends on lpd_pkg, lpd_ram (line memory) and lpd_rsp_reg (result register)
//
//   channel  ports                                    handshake
//   req      req_pixel_value                          req_valid / req_stall
//   rsp      rsp_peak_row rsp_peak_col rsp_is_peak    rsp_valid / rsp_stall
//            rsp_frame_end
//   csr      csr_index csr_data                       csr_valid / csr_ready
//
// each pixel goes through accept, two reads of the single read port of the line
// memory (this column, then the one to its right), then evaluate and write back
// the final pixel of a frame may add flush steps that emit the remaining last-row flags
// a full, stalled result register holds the evaluate step, and any flush step that emits
// reset clears control state and last-row flags; the line memory needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module raster_local_peak_detect_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [lpd_pkg::VALUE_BITS-1:0] req_pixel_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [lpd_pkg::ROW_BITS-1:0]              rsp_peak_row,
   output logic [lpd_pkg::COL_BITS-1:0]              rsp_peak_col,
   output logic                                      rsp_is_peak,
   output logic                                      rsp_frame_end,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lpd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int COLB = lpd_pkg::COL_BITS;
   localparam int ROWB = lpd_pkg::ROW_BITS;
   localparam int VB   = lpd_pkg::VALUE_BITS;
   localparam int CRB  = lpd_pkg::CFG_ROWS_BITS;
   localparam int CCB  = lpd_pkg::CFG_COLS_BITS;

   lpd_pkg::state_type state_ff, state_in;

   logic [CRB-1:0] cfg_rows_ff, cfg_rows_in;
   logic [CCB-1:0] cfg_cols_ff, cfg_cols_in;
   logic [ROWB-1:0] row_ff, row_in;
   logic [COLB-1:0] col_ff, col_in;
   logic [COLB-1:0] k_ff, k_in;
   logic [lpd_pkg::MAX_COLS-1:0] flags_ff, flags_in;

   lpd_pkg::value_type px_ff, px_in;
   lpd_pkg::value_type center_ff, center_in;
   lpd_pkg::value_type two_ff, two_in;
   lpd_pkg::value_type right_ff, right_in;
   lpd_pkg::value_type left_ff, left_in;
   lpd_pkg::value_type prev_px_ff, prev_px_in;

   logic [CRB-1:0]  eff_rows;
   logic [CCB-1:0]  eff_cols;
   logic [ROWB-1:0] last_row;
   logic [COLB-1:0] last_col;
   logic            on_last_row;
   logic            on_last_col;
   logic            final_px;
   logic            peak_ok;
   logic [lpd_pkg::MAX_COLS-1:0] flags_eval;
   logic [lpd_pkg::MAX_COLS-1:0] flags_left;

   logic                         mem_we;
   logic [COLB-1:0]              rd_addr;
   logic [lpd_pkg::LINE_BITS-1:0] rd_data;
   logic                         out_free;
   logic                         emit;
   lpd_pkg::rsp_type             emit_item;

   // frame size, clamped
   always_comb begin
      if (cfg_rows_ff < CRB'(2)) begin
         eff_rows = CRB'(2);
      end else if (cfg_rows_ff > CRB'(lpd_pkg::MAX_ROWS)) begin
         eff_rows = CRB'(lpd_pkg::MAX_ROWS);
      end else begin
         eff_rows = cfg_rows_ff;
      end
      if (cfg_cols_ff < CCB'(2)) begin
         eff_cols = CCB'(2);
      end else if (cfg_cols_ff > CCB'(lpd_pkg::MAX_COLS)) begin
         eff_cols = CCB'(lpd_pkg::MAX_COLS);
      end else begin
         eff_cols = cfg_cols_ff;
      end
   end

   assign last_row    = ROWB'(eff_rows - 1'b1);
   assign last_col    = COLB'(eff_cols - 1'b1);
   assign on_last_row = (row_ff == last_row);
   assign on_last_col = (col_ff == last_col);
   assign final_px    = on_last_row && on_last_col;

   // decision for the pixel above the arriving one
   assign peak_ok = (row_ff != '0)
                    && (center_ff >= px_ff)
                    && ((col_ff == '0) || (center_ff >= left_ff))
                    && (on_last_col || (center_ff >= right_ff))
                    && ((row_ff == ROWB'(1)) || (center_ff >= two_ff));

   // last-row candidate flags
   always_comb begin
      flags_eval = flags_ff;
      if (on_last_row) begin
         if ((col_ff != '0) && (prev_px_ff < px_ff)) begin
            flags_eval[COLB'(col_ff - 1'b1)] = 1'b0;
         end
         flags_eval[col_ff] = (px_ff >= center_ff)
                              && ((col_ff == '0) || (px_ff >= prev_px_ff));
      end
   end

   always_comb begin
      flags_left        = flags_ff;
      flags_left[k_ff]  = 1'b0;
   end

   assign rd_addr   = (state_ff == lpd_pkg::S_RD_C) ? COLB'(col_ff + 1'b1) : col_ff;
   assign req_stall = (state_ff != lpd_pkg::S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == lpd_pkg::S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cfg_rows_in = cfg_rows_ff;
      cfg_cols_in = cfg_cols_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      flags_in    = flags_ff;
      px_in       = px_ff;
      center_in   = center_ff;
      two_in      = two_ff;
      right_in    = right_ff;
      left_in     = left_ff;
      prev_px_in  = prev_px_ff;
      mem_we      = 1'b0;
      emit        = 1'b0;
      emit_item.row       = ROWB'(row_ff - 1'b1);
      emit_item.col       = col_ff;
      emit_item.is_peak   = 1'b1;
      emit_item.frame_end = 1'b0;
      case (state_ff)
         lpd_pkg::S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == lpd_pkg::REG_FRAME_ROWS) begin
                  cfg_rows_in = csr_data[CRB-1:0];
                  row_in      = '0;
                  col_in      = '0;
                  flags_in    = '0;
               end else if (csr_index == lpd_pkg::REG_FRAME_COLS) begin
                  cfg_cols_in = csr_data[CCB-1:0];
                  row_in      = '0;
                  col_in      = '0;
                  flags_in    = '0;
               end
            end else if (req_valid) begin
               px_in    = req_pixel_value;
               state_in = lpd_pkg::S_RD_C;
            end
         end
         lpd_pkg::S_RD_C: begin
            center_in = rd_data[lpd_pkg::LINE_BITS-1:VB];
            two_in    = rd_data[VB-1:0];
            state_in  = lpd_pkg::S_RD_N;
         end
         lpd_pkg::S_RD_N: begin
            right_in = rd_data[lpd_pkg::LINE_BITS-1:VB];
            state_in = lpd_pkg::S_EVAL;
         end
         lpd_pkg::S_EVAL: begin
            if (out_free) begin
               mem_we     = 1'b1;
               left_in    = center_ff;
               prev_px_in = px_ff;
               emit       = peak_ok;
               emit_item.frame_end = final_px && (flags_eval == '0);
               if (on_last_col) begin
                  col_in = '0;
                  row_in = on_last_row ? '0 : ROWB'(row_ff + 1'b1);
               end else begin
                  col_in = COLB'(col_ff + 1'b1);
               end
               if (final_px && (flags_eval == '0)) begin
                  flags_in = '0;
                  state_in = lpd_pkg::S_IDLE;
                  if (!peak_ok) begin
                     emit                = 1'b1;
                     emit_item.row       = '0;
                     emit_item.col       = '0;
                     emit_item.is_peak   = 1'b0;
                     emit_item.frame_end = 1'b1;
                  end
               end else if (final_px) begin
                  flags_in = flags_eval;
                  k_in     = '0;
                  state_in = lpd_pkg::S_FLUSH;
               end else begin
                  flags_in = flags_eval;
                  state_in = lpd_pkg::S_IDLE;
               end
            end
         end
         lpd_pkg::S_FLUSH: begin
            emit_item.row       = last_row;
            emit_item.col       = k_ff;
            emit_item.frame_end = (flags_left == '0);
            if (!flags_ff[k_ff]) begin
               k_in = COLB'(k_ff + 1'b1);
            end else if (out_free) begin
               emit     = 1'b1;
               flags_in = flags_left;
               k_in     = COLB'(k_ff + 1'b1);
               if (flags_left == '0) begin
                  state_in = lpd_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = lpd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpd_pkg::S_IDLE;
         cfg_rows_ff <= lpd_pkg::ROWS_RESET;
         cfg_cols_ff <= lpd_pkg::COLS_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         flags_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         cfg_rows_ff <= cfg_rows_in;
         cfg_cols_ff <= cfg_cols_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      center_ff  <= center_in;
      two_ff     <= two_in;
      right_ff   <= right_in;
      left_ff    <= left_in;
      prev_px_ff <= prev_px_in;
   end

   // line memory: row above in the upper half, row two above in the lower half
   lpd_ram #(
      .WIDTH (lpd_pkg::LINE_BITS),
      .DEPTH (lpd_pkg::MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (col_ff),
      .wr_data ({px_ff, center_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lpd_rsp_reg u_rsp_reg (
      .clock         (clock),
      .reset         (reset),
      .load          (emit),
      .item          (emit_item),
      .free          (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_peak_row  (rsp_peak_row),
      .rsp_peak_col  (rsp_peak_col),
      .rsp_is_peak   (rsp_is_peak),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

>>> test/raster_local_peak_detect_core_tb.sv
// raster_local_peak_detect_core_tb: self-checking bench for the 4-neighbour peak detector
// depends on lpd_pkg and raster_local_peak_detect_core; needs no files or arguments
// pixels go in through a queue-fed driver, peaks are predicted on acceptance and checked in order
`timescale 1ns / 1ps

module raster_local_peak_detect_core_tb;

   localparam int CSR_INDEX_BITS = lpd_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = lpd_pkg::CSR_DATA_BITS;
   localparam int CFG_ROWS_BITS  = lpd_pkg::CFG_ROWS_BITS;
   localparam int CFG_COLS_BITS  = lpd_pkg::CFG_COLS_BITS;
   localparam int ROW_BITS       = lpd_pkg::ROW_BITS;
   localparam int COL_BITS       = lpd_pkg::COL_BITS;
   localparam int MAX_ROWS       = lpd_pkg::MAX_ROWS;
   localparam int MAX_COLS       = lpd_pkg::MAX_COLS;

   typedef lpd_pkg::value_type value_type;
   typedef lpd_pkg::rsp_type   rsp_type;

   localparam int RANDOM_PIXELS  = 280;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // no register at this index
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   localparam value_type MOST_NEG = 16'sh8000;
   localparam value_type MOST_POS = 16'sh7FFF;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   value_type                 req_pixel_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ROW_BITS-1:0]       rsp_peak_row;
   logic [COL_BITS-1:0]       rsp_peak_col;
   logic                      rsp_is_peak;
   logic                      rsp_frame_end;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   raster_local_peak_detect_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_peak_row    (rsp_peak_row),
      .rsp_peak_col    (rsp_peak_col),
      .rsp_is_peak     (rsp_is_peak),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // detector state as seen by the predictor
   logic [CFG_ROWS_BITS-1:0] cfg_rows = lpd_pkg::ROWS_RESET;
   logic [CFG_COLS_BITS-1:0] cfg_cols = lpd_pkg::COLS_RESET;
   value_type   above_line [MAX_COLS];
   value_type   two_above_line [MAX_COLS];
   bit          bottom_flags [MAX_COLS];
   value_type   left_above;
   int unsigned cur_row = 0;
   int unsigned cur_col = 0;

   value_type pixels_todo [$];
   rsp_type   peaks_due [$];

   int  idle_pct = 10;
   int  hold_requests = 0;
   int  holds_served = 0;
   int  hold_left = 0;
   bit  pixel_taken = 1'b0;
   int  quiet_cycles = 0;

   int  errors = 0;
   int  pixels_accepted = 0;
   int  peaks_seen = 0;
   int  markers_seen = 0;
   int  frames_closed = 0;
   int  input_held = 0;
   int  csr_writes = 0;
   int  cut_frames = 0;

   function automatic int unsigned frame_height();
      if (cfg_rows < 2) return 2;
      if (cfg_rows > MAX_ROWS) return MAX_ROWS;
      return cfg_rows;
   endfunction

   function automatic int unsigned frame_width();
      if (cfg_cols < 2) return 2;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
   endfunction

   function automatic void restart_frame();
      cur_row = 0;
      cur_col = 0;
      foreach (bottom_flags[k]) bottom_flags[k] = 1'b0;
   endfunction

   function automatic void queue_peak(int unsigned row, int unsigned col, bit peak);
      rsp_type item;
      item.row       = ROW_BITS'(row);
      item.col       = COL_BITS'(col);
      item.is_peak   = peak;
      item.frame_end = 1'b0;
      peaks_due.push_back(item);
   endfunction

   // each pixel settles the one above it; the bottom row is settled at the final pixel
   function automatic void predict_pixel(value_type px);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      int          emitted;
      value_type   centre;
      value_type   left_now;
      bit          ok;
      bit          flag;
      rows    = frame_height();
      cols    = frame_width();
      r       = cur_row;
      c       = cur_col;
      emitted = 0;
      if (r >= 1) begin
         centre = above_line[c];
         ok = centre >= px;
         if (c > 0) ok = ok && (centre >= left_above);
         if (c + 1 < cols) ok = ok && (centre >= above_line[c + 1]);
         if (r >= 2) ok = ok && (centre >= two_above_line[c]);
         if (ok) begin
            queue_peak(r - 1, c, 1'b1);
            emitted++;
         end
      end
      if (r == rows - 1) begin
         flag = px >= above_line[c];
         if (c > 0) begin
            left_now = above_line[c - 1];
            flag = flag && (px >= left_now);
            if (left_now < px) bottom_flags[c - 1] = 1'b0;
         end
         bottom_flags[c] = flag;
      end
      left_above        = above_line[c];
      two_above_line[c] = above_line[c];
      above_line[c]     = px;
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) begin
            for (int unsigned k = 0; k < cols; k++) begin
               if (bottom_flags[k]) begin
                  queue_peak(rows - 1, k, 1'b1);
                  emitted++;
               end
            end
            if (emitted == 0) queue_peak(0, 0, 1'b0);
            peaks_due[peaks_due.size() - 1].frame_end = 1'b1;
            r = 0;
            foreach (bottom_flags[k]) bottom_flags[k] = 1'b0;
         end
      end
      cur_row = r;
      cur_col = c;
   endfunction

   function automatic value_type random_pixel(int style);
      case (style)
         0: return value_type'($urandom);
         1: return value_type'(int'($urandom_range(4)) - 2);
         2: begin
            case ($urandom_range(3))
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return value_type'(0);
               default: return value_type'(-1);
            endcase
         end
         default: begin
            if ($urandom_range(1) == 0) return value_type'($urandom);
            return value_type'(int'($urandom_range(4)) - 2);
         end
      endcase
   endfunction

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_taken) begin
         if (pixels_todo.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_valid       <= 1'b1;
            req_pixel_value <= pixels_todo.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure, with the long hold counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // monitor: check results first, then predict from the pixel taken at this edge
   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      pixel_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_peak_row, rsp_peak_col, rsp_is_peak, rsp_frame_end};
            if (got.is_peak) peaks_seen++;
            else if (got.frame_end) markers_seen++;
            if (got.frame_end) frames_closed++;
            if (peaks_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected item: row %0d col %0d peak %0b end %0b",
                           got.row, got.col, got.is_peak, got.frame_end);
            end else begin
               want = peaks_due.pop_front();
               if (got != want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"mismatch: expected row %0d col %0d peak %0b end %0b,",
                               " got row %0d col %0d peak %0b end %0b"},
                              want.row, want.col, want.is_peak, want.frame_end,
                              got.row, got.col, got.is_peak, got.frame_end);
               end
            end
         end
         if (req_valid && req_stall) input_held++;
         if (req_valid && !req_stall) begin
            pixels_accepted++;
            predict_pixel(req_pixel_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d items outstanding",
                  quiet_cycles, peaks_due.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == lpd_pkg::REG_FRAME_ROWS) begin
         cfg_rows = data;
         restart_frame();
      end else if (index == lpd_pkg::REG_FRAME_COLS) begin
         cfg_cols = data[CFG_COLS_BITS-1:0];
         restart_frame();
      end
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [CSR_DATA_BITS-1:0] rows_data,
                            input logic [CSR_DATA_BITS-1:0] cols_data);
      csr_write(lpd_pkg::REG_FRAME_ROWS, rows_data);
      csr_write(lpd_pkg::REG_FRAME_COLS, cols_data);
   endtask

   task automatic wait_results();
      while (pixels_todo.size() != 0 || req_valid || peaks_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] rows_data;
      logic [CSR_DATA_BITS-1:0] cols_data;
      int unsigned height;
      int unsigned width;
      int phase;
      int frames;
      int style;
      int count;
      int which;
      int random_pixels;
      random_pixels = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: spare index, smallest frame with ties, extremes
      csr_write(REG_SPARE, 11'h7FF);
      set_frame(11'd2, 11'd2);
      pixels_todo = {pixels_todo, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                     MOST_POS, MOST_NEG, MOST_NEG, MOST_POS,
                     value_type'(-3), value_type'(-2), value_type'(-1), value_type'(0),
                     value_type'(5), value_type'(1), value_type'(1), value_type'(0)};
      drain();
      set_frame(11'd3, 11'd3);
      pixels_todo = {pixels_todo, value_type'(-1), value_type'(-1), value_type'(-1),
                     value_type'(-1), MOST_POS, value_type'(-1),
                     value_type'(0), value_type'(-1), value_type'(-1)};

      for (phase = 0; random_pixels < RANDOM_PIXELS; phase++) begin
         drain();
         idle_pct = (phase == 0 || phase == 4) ? 0 : 10;
         if (phase == 1) begin
            // wide frame of near-ties while results are held back
            set_frame(11'd3, 11'd32);
            hold_requests++;
         end else if (phase == 3) begin
            // both registers above range, frame cut short by the next write
            set_frame(11'h7FF, 11'h03F);
         end else begin
            rows_data = ($urandom_range(7) == 0) ? CSR_DATA_BITS'($urandom_range(1))
                                                 : CSR_DATA_BITS'($urandom_range(2, 4));
            case ($urandom_range(7))
               0: cols_data = CSR_DATA_BITS'($urandom_range(1));
               1: cols_data = {5'($urandom), 6'($urandom_range(2, 6))};
               2: cols_data = CSR_DATA_BITS'($urandom_range(9, 31));
               default: cols_data = CSR_DATA_BITS'($urandom_range(2, 6));
            endcase
            which = (frame_height() > 5) ? 2 : $urandom_range(3);
            case (which)
               0: csr_write(lpd_pkg::REG_FRAME_ROWS, rows_data);
               1: csr_write(lpd_pkg::REG_FRAME_COLS, cols_data);
               default: set_frame(rows_data, cols_data);
            endcase
         end
         height = frame_height();
         width  = frame_width();
         frames = (phase == 1 || phase == 3 || width > 8) ? 1 : $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            style = (phase == 1) ? 1 : $urandom_range(3);
            count = height * width;
            if (phase == 3)
               count = 2 * width + 5;
            else if (phase != 1 && f == frames - 1 && $urandom_range(4) == 0)
               count = $urandom_range(1, count - 1);
            if (count != height * width) cut_frames++;
            for (int p = 0; p < count; p++) begin
               // sender stops mid-frame until everything owed has come back
               if (phase == 2 && f == 0 && p == count / 2) wait_results();
               pixels_todo.push_back(random_pixel(style));
            end
            random_pixels += count;
         end
      end

      drain();
      $display("covered %0d pixels, %0d register writes, %0d frames cut short by a restart",
               pixels_accepted, csr_writes, cut_frames);
      $display("saw %0d peaks, %0d frame ends, %0d empty frame markers, input held %0d cycles",
               peaks_seen, frames_closed, markers_seen, input_held);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
